// ----- sv/mse_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg: shared types and codes of the MIPS subset execute step
// Instruction kinds, error codes and result source selects.
// ----------------------------------------------------------------------------
package mse_pkg;

    typedef logic [3:0]  kind_t;
    typedef logic [4:0]  reg_idx_t;
    typedef logic [10:0] line_t;
    typedef logic [31:0] word_t;
    typedef logic [2:0]  err_t;
    typedef logic [1:0]  src_sel_t;

    localparam kind_t KIND_ADD   = 4'd0;
    localparam kind_t KIND_ADDI  = 4'd1;
    localparam kind_t KIND_SUB   = 4'd2;
    localparam kind_t KIND_MUL   = 4'd3;
    localparam kind_t KIND_BEQ   = 4'd4;
    localparam kind_t KIND_BNE   = 4'd5;
    localparam kind_t KIND_SLT   = 4'd6;
    localparam kind_t KIND_LW    = 4'd7;
    localparam kind_t KIND_SW    = 4'd8;
    localparam kind_t KIND_J     = 4'd9;
    localparam kind_t KIND_BLANK = 4'd10;

    localparam int NUM_OPS = 10;

    localparam err_t ERR_NONE       = 3'd0;
    localparam err_t ERR_MISALIGNED = 3'd1;
    localparam err_t ERR_RANGE      = 3'd2;
    localparam err_t ERR_ZERO_WRITE = 3'd3;
    localparam err_t ERR_TARGET     = 3'd4;
    localparam err_t ERR_STACK_MT   = 3'd5;
    localparam err_t ERR_STACK_FULL = 3'd6;

    localparam src_sel_t SRC_ALU   = 2'd0;
    localparam src_sel_t SRC_MEM   = 2'd1;
    localparam src_sel_t SRC_STACK = 2'd2;

endpackage
`default_nettype wire

// ----- sv/mse_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mse_ram: generic single-clock RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- sv/mips_subset_execute_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mips_subset_execute_step: executes one decoded MIPS subset instruction
// Register file, data memory and stack live in synchronous RAMs; each
// transaction is read, checked and written back.
// ----------------------------------------------------------------------------
// Result: each transaction passes the execute and write-back stages and is then
// registered onto m_tdata. A new transaction is taken only with the execute
// stage empty, so its read never comes before the write-back of the one ahead.
// Reset: synchronous, active low. After reset the data memory is cleared one
// word per cycle over all MEM_WORDS words, with s_tready low; cfg writes are taken.
module mips_subset_execute_step
    import mse_pkg::*;
#(
    parameter int MEM_WORDS   = 262144,
    parameter int STACK_DEPTH = 256,
    parameter int PROG_MAX    = 1024
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // dest_reg[4:0], src_a[9:5], src_b[14:10], immediate[46:15], target_line[57:47]
    input  wire logic [63:0]  s_tdata,
    // kind[3:0]
    input  wire logic [3:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // next_line[10:0], finished[11], error_code[14:12], reg_write_valid[15],
    // written_reg[20:16], written_value[52:21], cycle_total[84:53],
    // opcode_count[116:85]
    output logic      [119:0] m_tdata,
    input  wire logic         cfg_wr_en,
    input  wire logic [10:0]  cfg_wr_data
);

    localparam int DM_AW = $clog2(MEM_WORDS);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int SL_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [SL_W-1:0]  STACK_FULL = SL_W'(STACK_DEPTH);
    localparam logic [DM_AW-1:0] CLR_LAST   = DM_AW'(MEM_WORDS - 1);
    localparam logic [29:0]      MEM_LIMIT  = 30'(MEM_WORDS);
    localparam line_t            PLEN_MAX   = (PROG_MAX > 2047) ? 11'd2047 : 11'(PROG_MAX);

    // Input fields
    kind_t    in_kind;
    reg_idx_t in_rd, in_ra, in_rb;
    word_t    in_imm;
    line_t    in_tgt;

    assign in_kind = s_tuser;
    assign in_rd   = s_tdata[4:0];
    assign in_ra   = s_tdata[9:5];
    assign in_rb   = s_tdata[14:10];
    assign in_imm  = s_tdata[46:15];
    assign in_tgt  = s_tdata[57:47];

    // Control and architectural state
    logic              clear_reg;
    logic [DM_AW-1:0]  clr_addr_reg;
    line_t             plen_reg;
    line_t             line_reg;
    word_t             cycle_reg;
    word_t             opcnt_reg [NUM_OPS];
    logic [SL_W-1:0]   level_reg;
    logic [31:0]       rf_valid_reg;
    logic              byp_valid_reg;
    reg_idx_t          byp_idx_reg;
    word_t             byp_val_reg;

    // Execute stage
    logic     x_valid_reg;
    kind_t    x_kind_reg;
    reg_idx_t x_rd_reg, x_ra_reg, x_rb_reg;
    word_t    x_imm_reg;
    line_t    x_tgt_reg;

    // Write-back stage
    logic     y_valid_reg;
    line_t    y_next_reg;
    logic     y_fin_reg;
    err_t     y_err_reg;
    logic     y_wr_reg;
    reg_idx_t y_rd_reg;
    word_t    y_wval_reg;
    src_sel_t y_src_reg;
    word_t    y_cycle_reg;
    word_t    y_opcnt_reg;

    logic          m_tvalid_reg;
    logic [119:0]  m_tdata_reg;

    logic s_accept, x_adv, y_fire;

    assign y_fire   = y_valid_reg && (!m_tvalid_reg || m_tready);
    assign x_adv    = x_valid_reg && (!y_valid_reg || y_fire);
    assign s_tready = !clear_reg && !x_valid_reg && (!y_valid_reg || y_fire);
    assign s_accept = s_tvalid && s_tready;

    // Register file: three copies give three read ports.
    word_t rf_a_q, rf_b_q, rf_d_q;
    word_t y_value;

    mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .clk(aclk), .wr_en(y_fire && y_wr_reg), .wr_addr(y_rd_reg), .wr_data(y_value),
        .rd_en(s_accept), .rd_addr(in_ra), .rd_data(rf_a_q)
    );
    mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .clk(aclk), .wr_en(y_fire && y_wr_reg), .wr_addr(y_rd_reg), .wr_data(y_value),
        .rd_en(s_accept), .rd_addr(in_rb), .rd_data(rf_b_q)
    );
    mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_d (
        .clk(aclk), .wr_en(y_fire && y_wr_reg), .wr_addr(y_rd_reg), .wr_data(y_value),
        .rd_en(s_accept), .rd_addr(in_rd), .rd_data(rf_d_q)
    );

    // Operand values: the bypass covers a write-back on the same edge as the
    // read, and a register never written reads as zero.
    word_t va, vb, vd;

    always_comb begin
        if (byp_valid_reg && byp_idx_reg == x_ra_reg) begin
            va = byp_val_reg;
        end else begin
            va = rf_valid_reg[x_ra_reg] ? rf_a_q : '0;
        end
        if (byp_valid_reg && byp_idx_reg == x_rb_reg) begin
            vb = byp_val_reg;
        end else begin
            vb = rf_valid_reg[x_rb_reg] ? rf_b_q : '0;
        end
        if (byp_valid_reg && byp_idx_reg == x_rd_reg) begin
            vd = byp_val_reg;
        end else begin
            vd = rf_valid_reg[x_rd_reg] ? rf_d_q : '0;
        end
    end

    // Execute logic
    word_t    addr;
    logic     tgt_ok;
    line_t    line_seq;
    line_t    line_next;
    err_t     x_err;
    logic     x_wr;
    word_t    x_wval;
    src_sel_t x_src;
    logic     x_load_mem, x_store_mem, x_pop, x_push;
    logic     counted;
    logic     commit;
    word_t    opcnt_cur;
    word_t    cycle_next;
    logic [29:0] widx;

    assign addr     = va + x_imm_reg;
    assign widx     = addr[31:2];
    assign tgt_ok   = (x_tgt_reg != '0) && (x_tgt_reg <= plen_reg);
    assign line_seq = line_reg + 11'd1;
    assign counted  = (x_kind_reg <= KIND_J);

    always_comb begin
        x_err       = ERR_NONE;
        x_wr        = 1'b0;
        x_wval      = '0;
        x_src       = SRC_ALU;
        x_load_mem  = 1'b0;
        x_store_mem = 1'b0;
        x_pop       = 1'b0;
        x_push      = 1'b0;
        line_next   = line_seq;
        case (x_kind_reg)
            KIND_ADD, KIND_ADDI, KIND_SUB, KIND_MUL: begin
                if (x_rd_reg == '0) begin
                    x_err = ERR_ZERO_WRITE;
                end else begin
                    x_wr = 1'b1;
                    case (x_kind_reg)
                        KIND_ADD:  x_wval = va + vb;
                        KIND_ADDI: x_wval = va + x_imm_reg;
                        KIND_SUB:  x_wval = va - vb;
                        default:   x_wval = va * vb;
                    endcase
                end
            end
            KIND_BEQ, KIND_BNE: begin
                if (!tgt_ok) begin
                    x_err = ERR_TARGET;
                end else if ((vd == va) == (x_kind_reg == KIND_BEQ)) begin
                    line_next = x_tgt_reg;
                end
            end
            KIND_SLT: begin
                // Writing register zero executes but stores nothing.
                if (x_rd_reg != '0) begin
                    x_wr   = 1'b1;
                    x_wval = {31'd0, $signed(va) < $signed(vb)};
                end
            end
            KIND_LW: begin
                if (x_rd_reg == '0) begin
                    x_err = ERR_ZERO_WRITE;
                end else if (addr[1:0] != 2'b00) begin
                    x_err = ERR_MISALIGNED;
                end else if (addr[31]) begin
                    if (level_reg == '0) begin
                        x_err = ERR_STACK_MT;
                    end else begin
                        x_wr  = 1'b1;
                        x_src = SRC_STACK;
                        x_pop = 1'b1;
                    end
                end else if (widx >= MEM_LIMIT) begin
                    x_err = ERR_RANGE;
                end else begin
                    x_wr       = 1'b1;
                    x_src      = SRC_MEM;
                    x_load_mem = 1'b1;
                end
            end
            KIND_SW: begin
                if (addr[1:0] != 2'b00) begin
                    x_err = ERR_MISALIGNED;
                end else if (addr[31]) begin
                    if (level_reg >= STACK_FULL) begin
                        x_err = ERR_STACK_FULL;
                    end else begin
                        x_push = 1'b1;
                    end
                end else if (widx >= MEM_LIMIT) begin
                    x_err = ERR_RANGE;
                end else begin
                    x_store_mem = 1'b1;
                end
            end
            KIND_J: begin
                if (!tgt_ok) begin
                    x_err = ERR_TARGET;
                end else begin
                    line_next = x_tgt_reg;
                end
            end
            default: begin
            end
        endcase
        if (x_err != ERR_NONE) begin
            line_next = line_reg;
            x_wr      = 1'b0;
            x_wval    = '0;
            x_src     = SRC_ALU;
        end
    end

    assign commit     = (x_err == ERR_NONE);
    assign cycle_next = cycle_reg + {31'd0, commit && counted};

    always_comb begin
        opcnt_cur = '0;
        for (int i = 0; i < NUM_OPS; i++) begin
            if (x_kind_reg == kind_t'(i)) begin
                opcnt_cur = opcnt_reg[i];
            end
        end
    end

    // Data memory, also swept to zero after reset.
    word_t dm_q;

    mse_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
        .clk(aclk),
        .wr_en(clear_reg || (x_adv && x_store_mem)),
        .wr_addr(clear_reg ? clr_addr_reg : widx[DM_AW-1:0]),
        .wr_data(clear_reg ? '0 : vd),
        .rd_en(x_adv && x_load_mem),
        .rd_addr(widx[DM_AW-1:0]),
        .rd_data(dm_q)
    );

    // Stack store
    word_t           st_q;
    logic [SL_W-1:0] level_dec;

    assign level_dec = level_reg - 1'b1;

    mse_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(aclk),
        .wr_en(x_adv && x_push),
        .wr_addr(level_reg[SA_W-1:0]),
        .wr_data(vd),
        .rd_en(x_adv && x_pop),
        .rd_addr(level_dec[SA_W-1:0]),
        .rd_data(st_q)
    );

    always_comb begin
        case (y_src_reg)
            SRC_MEM:   y_value = dm_q;
            SRC_STACK: y_value = st_q;
            default:   y_value = y_wval_reg;
        endcase
    end

    // Sequential logic
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg     <= 1'b1;
            clr_addr_reg  <= '0;
            plen_reg      <= 11'd1;
            line_reg      <= 11'd1;
            cycle_reg     <= '0;
            level_reg     <= '0;
            rf_valid_reg  <= '0;
            byp_valid_reg <= 1'b0;
            x_valid_reg   <= 1'b0;
            y_valid_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < NUM_OPS; i++) begin
                opcnt_reg[i] <= '0;
            end
        end else begin
            if (clear_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLR_LAST) begin
                    clear_reg <= 1'b0;
                end
            end

            if (cfg_wr_en) begin
                plen_reg <= (cfg_wr_data > PLEN_MAX) ? PLEN_MAX : cfg_wr_data;
            end

            if (s_accept) begin
                x_valid_reg <= 1'b1;
            end else if (x_adv) begin
                x_valid_reg <= 1'b0;
            end

            if (x_adv) begin
                y_valid_reg <= 1'b1;
                if (commit) begin
                    line_reg  <= line_next;
                    cycle_reg <= cycle_next;
                    for (int i = 0; i < NUM_OPS; i++) begin
                        if (x_kind_reg == kind_t'(i)) begin
                            opcnt_reg[i] <= opcnt_reg[i] + 1'b1;
                        end
                    end
                    if (x_push) begin
                        level_reg <= level_reg + 1'b1;
                    end else if (x_pop) begin
                        level_reg <= level_dec;
                    end
                end
            end else if (y_fire) begin
                y_valid_reg <= 1'b0;
            end

            if (y_fire) begin
                m_tvalid_reg <= 1'b1;
                if (y_wr_reg) begin
                    rf_valid_reg[y_rd_reg] <= 1'b1;
                    byp_valid_reg          <= 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x_kind_reg <= in_kind;
            x_rd_reg   <= in_rd;
            x_ra_reg   <= in_ra;
            x_rb_reg   <= in_rb;
            x_imm_reg  <= in_imm;
            x_tgt_reg  <= in_tgt;
        end
        if (x_adv) begin
            y_next_reg  <= line_next;
            y_fin_reg   <= (line_next > plen_reg);
            y_err_reg   <= x_err;
            y_wr_reg    <= x_wr;
            y_rd_reg    <= x_wr ? x_rd_reg : '0;
            y_wval_reg  <= x_wval;
            y_src_reg   <= x_src;
            y_cycle_reg <= cycle_next;
            y_opcnt_reg <= counted ? (opcnt_cur + {31'd0, commit}) : '0;
        end
        if (y_fire) begin
            m_tdata_reg <= {3'd0, y_opcnt_reg, y_cycle_reg, y_value, y_rd_reg,
                            y_wr_reg, y_err_reg, y_fin_reg, y_next_reg};
            if (y_wr_reg) begin
                byp_idx_reg <= y_rd_reg;
                byp_val_reg <= y_value;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

// ----- sv/mse_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mse_checker: port-level checks of the MIPS subset execute step
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module mse_checker
    import mse_pkg::*;
(
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [119:0] m_tdata
);

    logic  seen_reg;
    word_t last_total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            seen_reg       <= 1'b1;
            last_total_reg <= m_tdata[84:53];
        end
    end

    // A stalled result transaction keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A step that reports an error never writes a register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[14:12] != ERR_NONE |-> !m_tdata[15])
        else $error("register write reported with an error");

    // Without a write the register number and value read as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[15] |-> m_tdata[20:16] == 5'd0 && m_tdata[52:21] == 32'd0)
        else $error("write fields not cleared");

    // Register zero is never reported as written.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15] |-> m_tdata[20:16] != 5'd0)
        else $error("register zero written");

    // The executed count grows by at most one from one result to the next.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && seen_reg |->
            m_tdata[84:53] == last_total_reg || m_tdata[84:53] == last_total_reg + 32'd1)
        else $error("cycle total jumped");

endmodule

bind mips_subset_execute_step mse_checker u_mse_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);
`default_nettype wire

// ----- sim/tb_mips_subset_execute_step.sv -----
// ----------------------------------------------------------------------------
// tb_mips_subset_execute_step: self-checking bench for the MIPS subset step
// Drives decoded instructions through the input stream and checks every
// result against a cycle-free model of the register file, data memory,
// stack and counters kept in this bench. A short directed table comes first.
// Random programs follow under several program lengths, with random gaps and
// stalls on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_mips_subset_execute_step;
    import mse_pkg::*;

    localparam int MEM_WORDS       = 262144;
    localparam int STACK_DEPTH     = 256;
    localparam int PROG_MAX        = 1024;
    localparam int ITEMS_PER_PHASE = 290;
    localparam int NUM_PHASES      = 5;
    localparam int HOLD_AFTER      = 400;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int LIMIT_CYCLES    = 2000000;
    localparam int MAX_REPORTS     = 30;

    typedef struct packed {
        kind_t    kind;
        line_t    tgt;
        word_t    imm;
        reg_idx_t rb;
        reg_idx_t ra;
        reg_idx_t rd;
    } instr_t;

    // Same bit order as m_tdata[116:0].
    typedef struct packed {
        word_t    opcode_count;
        word_t    cycle_total;
        word_t    written_value;
        reg_idx_t written_reg;
        logic     reg_write;
        err_t     error_code;
        logic     finished;
        line_t    next_line;
    } result_t;

    typedef struct packed {
        instr_t  ins;
        logic    typed;
        result_t want;
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;     // dest_reg, src_a, src_b, immediate, target_line
    logic [3:0]   s_tuser;     // kind
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;     // next_line, finished, error_code, reg_write_valid,
                               // written_reg, written_value, cycle_total,
                               // opcode_count
    logic         cfg_wr_en;
    logic [10:0]  cfg_wr_data;

    // Predicted machine state.
    bit [31:0]   gpr [32];
    bit [31:0]   dmem [MEM_WORDS];
    bit [31:0]   stk [STACK_DEPTH];
    int unsigned stk_level;
    int unsigned stk_peak;
    line_t       cur_line;
    line_t       prog_len;
    bit [31:0]   exec_total;
    bit [31:0]   op_counts [NUM_OPS];

    result_t     pending_results[$];
    dir_row_t    dir_rows[$];
    int          mismatches;
    int          results_seen;
    int          items_sent;
    int          error_results;
    bit          held_off;
    bit          tx_calm;

    mips_subset_execute_step #(
        .MEM_WORDS(MEM_WORDS),
        .STACK_DEPTH(STACK_DEPTH),
        .PROG_MAX(PROG_MAX)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    function automatic result_t execute_instr(instr_t it);
        result_t r;
        word_t   va;
        word_t   vb;
        word_t   addr;
        word_t   wval;
        line_t   nxt;
        err_t    err;
        logic    wr;
        logic    counted;
        logic    tgt_ok;
        va = gpr[it.ra];
        vb = gpr[it.rb];
        addr = va + it.imm;
        nxt = cur_line + 11'd1;
        err = ERR_NONE;
        wr = 1'b0;
        wval = '0;
        counted = (it.kind <= KIND_J);
        tgt_ok = (it.tgt >= 11'd1) && (it.tgt <= prog_len);
        case (it.kind)
            KIND_ADD, KIND_ADDI, KIND_SUB, KIND_MUL: begin
                if (it.rd == 5'd0) begin
                    err = ERR_ZERO_WRITE;
                end else begin
                    wr = 1'b1;
                    case (it.kind)
                        KIND_ADD:  wval = va + vb;
                        KIND_ADDI: wval = va + it.imm;
                        KIND_SUB:  wval = va - vb;
                        default:   wval = va * vb;
                    endcase
                end
            end
            KIND_BEQ, KIND_BNE: begin
                if (!tgt_ok) begin
                    err = ERR_TARGET;
                end else if ((gpr[it.rd] == va) == (it.kind == KIND_BEQ)) begin
                    nxt = it.tgt;
                end
            end
            KIND_SLT: begin
                // Register zero is never written, but the step still counts.
                if (it.rd != 5'd0) begin
                    wr = 1'b1;
                    wval = ($signed(va) < $signed(vb)) ? 32'd1 : 32'd0;
                end
            end
            KIND_LW: begin
                if (it.rd == 5'd0) begin
                    err = ERR_ZERO_WRITE;
                end else if (addr[1:0] != 2'b00) begin
                    err = ERR_MISALIGNED;
                end else if (addr[31]) begin
                    if (stk_level == 0) begin
                        err = ERR_STACK_MT;
                    end else begin
                        wr = 1'b1;
                        wval = stk[stk_level - 1];
                        stk_level--;
                    end
                end else if (addr[31:2] >= MEM_WORDS) begin
                    err = ERR_RANGE;
                end else begin
                    wr = 1'b1;
                    wval = dmem[addr[31:2]];
                end
            end
            KIND_SW: begin
                if (addr[1:0] != 2'b00) begin
                    err = ERR_MISALIGNED;
                end else if (addr[31]) begin
                    if (stk_level >= STACK_DEPTH) begin
                        err = ERR_STACK_FULL;
                    end else begin
                        stk[stk_level] = gpr[it.rd];
                        stk_level++;
                        if (stk_level > stk_peak) stk_peak = stk_level;
                    end
                end else if (addr[31:2] >= MEM_WORDS) begin
                    err = ERR_RANGE;
                end else begin
                    dmem[addr[31:2]] = gpr[it.rd];
                end
            end
            KIND_J: begin
                if (!tgt_ok) err = ERR_TARGET;
                else nxt = it.tgt;
            end
            default: begin
            end
        endcase
        if (err != ERR_NONE) begin
            nxt = cur_line;
            wr = 1'b0;
            wval = '0;
        end else begin
            if (wr) gpr[it.rd] = wval;
            if (counted) begin
                exec_total++;
                op_counts[it.kind]++;
            end
            cur_line = nxt;
        end
        r.next_line = nxt;
        r.finished = (nxt > prog_len);
        r.error_code = err;
        r.reg_write = wr;
        r.written_reg = wr ? it.rd : 5'd0;
        r.written_value = wval;
        r.cycle_total = exec_total;
        r.opcode_count = counted ? op_counts[it.kind] : 32'd0;
        return r;
    endfunction

    function automatic instr_t op(kind_t k, reg_idx_t rd, reg_idx_t ra, reg_idx_t rb,
                                  word_t imm, line_t tgt);
        instr_t i;
        i.kind = k;
        i.rd = rd;
        i.ra = ra;
        i.rb = rb;
        i.imm = imm;
        i.tgt = tgt;
        return i;
    endfunction

    // Result of a step that writes nothing while the line count is still 1.
    function automatic result_t early_result(line_t nl, err_t e);
        result_t r;
        r = '0;
        r.next_line = nl;
        r.finished = 1'b1;
        r.error_code = e;
        return r;
    endfunction

    task automatic add_row(instr_t ins, logic typed, result_t want);
        dir_row_t row;
        row.ins = ins;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic word_t stack_address();
        return ($urandom() | 32'h8000_0000) & 32'hFFFF_FFFC;
    endfunction

    function automatic word_t pick_address();
        int    r;
        word_t a;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            a = $urandom_range(0, 63) << 2;
        end else if (r < 55) begin
            a = (MEM_WORDS - 1 - $urandom_range(0, 15)) << 2;
        end else if (r < 65) begin
            a = $urandom();
            if (a[1:0] == 2'b00) a[0] = 1'b1;
        end else if (r < 75) begin
            a = $urandom_range(MEM_WORDS, 32'h1FFF_FFFF) << 2;
        end else begin
            a = stack_address();
        end
        return a;
    endfunction

    function automatic word_t pick_const();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return $urandom_range(0, 32) - 16;
        if (r < 45) begin
            case ($urandom_range(0, 4))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'hFFFF_FFFF;
                3:       return 32'd1;
                default: return 32'd0;
            endcase
        end
        if (r < 60) return $urandom_range(0, 63) << 2;
        return $urandom();
    endfunction

    function automatic line_t pick_target();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 11'd0;
        if (r == 1) return $urandom_range(0, PROG_MAX);
        return $urandom_range(1, prog_len);
    endfunction

    // Unused fields carry random bits; the block must ignore them.
    function automatic instr_t random_instr();
        instr_t i;
        int     r;
        r = $urandom_range(0, 99);
        i.rd = ($urandom_range(0, 99) < 6) ? 5'd0 : 5'($urandom_range(1, 31));
        i.ra = $urandom_range(0, 31);
        i.rb = $urandom_range(0, 31);
        i.imm = $urandom();
        i.tgt = $urandom_range(0, PROG_MAX);
        if (r < 10)      i.kind = KIND_ADD;
        else if (r < 20) i.kind = KIND_ADDI;
        else if (r < 26) i.kind = KIND_SUB;
        else if (r < 32) i.kind = KIND_MUL;
        else if (r < 40) i.kind = KIND_SLT;
        else if (r < 48) i.kind = KIND_BEQ;
        else if (r < 56) i.kind = KIND_BNE;
        else if (r < 62) i.kind = KIND_J;
        else if (r < 77) i.kind = KIND_LW;
        else if (r < 93) i.kind = KIND_SW;
        else if (r < 96) i.kind = KIND_BLANK;
        else             i.kind = $urandom_range(11, 15);
        case (i.kind)
            KIND_ADDI: i.imm = pick_const();
            KIND_BEQ, KIND_BNE: begin
                if ($urandom_range(0, 1) == 0) i.ra = i.rd;
                i.tgt = pick_target();
            end
            KIND_J: i.tgt = pick_target();
            KIND_LW, KIND_SW: begin
                // Offset is chosen so the effective address lands in a wanted class.
                if ($urandom_range(0, 9) != 0) i.imm = pick_address() - gpr[i.ra];
            end
            default: begin
            end
        endcase
        return i;
    endfunction

    function automatic instr_t stack_instr(kind_t k);
        instr_t i;
        i = op(k, $urandom_range(1, 31), $urandom_range(0, 31), $urandom_range(0, 31),
               32'd0, $urandom_range(0, PROG_MAX));
        i.imm = stack_address() - gpr[i.ra];
        return i;
    endfunction

    task automatic send_instr(instr_t it, logic typed, result_t want);
        int      gap;
        result_t predicted;
        if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= {6'd0, it.tgt, it.imm, it.rb, it.ra, it.rd};
        do @(posedge aclk); while (!s_tready);
        predicted = execute_instr(it);
        pending_results.push_back(typed ? want : predicted);
        if (predicted.error_code != ERR_NONE) error_results++;
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_program_length(line_t value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        prog_len = (value > PROG_MAX) ? line_t'(PROG_MAX) : value;
    endtask

    task automatic flag_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got_v, want_v, $time);
    endtask

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[116:0];
            results_seen++;
            if (m_tdata[119:117] != 3'd0) flag_mismatch("padding", m_tdata[119:117], 0);
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected transaction", got.next_line, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.next_line != want.next_line)
                    flag_mismatch("next_line", got.next_line, want.next_line);
                if (got.finished != want.finished)
                    flag_mismatch("finished", got.finished, want.finished);
                if (got.error_code != want.error_code)
                    flag_mismatch("error_code", got.error_code, want.error_code);
                if (got.reg_write != want.reg_write)
                    flag_mismatch("reg_write_valid", got.reg_write, want.reg_write);
                if (got.written_reg != want.written_reg)
                    flag_mismatch("written_reg", got.written_reg, want.written_reg);
                if (got.written_value != want.written_value)
                    flag_mismatch("written_value", got.written_value, want.written_value);
                if (got.cycle_total != want.cycle_total)
                    flag_mismatch("cycle_total", got.cycle_total, want.cycle_total);
                if (got.opcode_count != want.opcode_count)
                    flag_mismatch("opcode_count", got.opcode_count, want.opcode_count);
            end
        end
    end

    initial begin : result_sink
        int stall;
        bit calm;
        stall = 0;
        calm = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            @(negedge aclk);
            // One long hold-off lets the block fill up and push back on its input.
            if (!held_off && results_seen >= HOLD_AFTER) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                held_off = 1'b1;
            end
            if ($urandom_range(0, 299) == 0) calm = !calm;
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = pick_gap(calm);
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 10);
        $display("tb_mips_subset_execute_step: errors");
        $finish;
    end

    initial begin : stimulus
        line_t lens [NUM_PHASES];
        int    waited;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        error_results = 0;
        held_off = 1'b0;
        tx_calm = 1'b0;
        stk_level = 0;
        stk_peak = 0;
        cur_line = 11'd1;
        prog_len = 11'd1;
        exec_total = '0;

        // Directed rows run with the reset program length of one line.
        add_row(op(KIND_BLANK, 5'd0, 5'd0, 5'd0, 32'd0, 11'd0), 1'b1,
                early_result(11'd2, ERR_NONE));
        add_row(op(4'd15, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 11'd1024), 1'b1,
                early_result(11'd3, ERR_NONE));
        add_row(op(KIND_ADD, 5'd0, 5'd1, 5'd2, 32'd0, 11'd0), 1'b1,
                early_result(11'd3, ERR_ZERO_WRITE));
        add_row(op(KIND_J, 5'd0, 5'd0, 5'd0, 32'd0, 11'd0), 1'b1,
                early_result(11'd3, ERR_TARGET));
        add_row(op(KIND_LW, 5'd5, 5'd0, 5'd0, 32'd2, 11'd0), 1'b1,
                early_result(11'd3, ERR_MISALIGNED));
        add_row(op(KIND_LW, 5'd5, 5'd0, 5'd0, 32'h0010_0000, 11'd0), 1'b1,
                early_result(11'd3, ERR_RANGE));
        add_row(op(KIND_LW, 5'd5, 5'd0, 5'd0, 32'hFFFF_FFFC, 11'd0), 1'b1,
                early_result(11'd3, ERR_STACK_MT));
        add_row(op(KIND_ADDI, 5'd1, 5'd0, 5'd0, 32'h7FFF_FFFF, 11'd0), 1'b0, '0);
        add_row(op(KIND_ADDI, 5'd2, 5'd0, 5'd0, 32'h8000_0000, 11'd0), 1'b0, '0);
        add_row(op(KIND_ADD, 5'd3, 5'd1, 5'd2, 32'd0, 11'd0), 1'b0, '0);
        add_row(op(KIND_ADD, 5'd4, 5'd1, 5'd1, 32'd0, 11'd0), 1'b0, '0);
        add_row(op(KIND_SUB, 5'd5, 5'd2, 5'd1, 32'd0, 11'd0), 1'b0, '0);
        add_row(op(KIND_MUL, 5'd6, 5'd1, 5'd1, 32'd0, 11'd0), 1'b0, '0);
        add_row(op(KIND_SLT, 5'd7, 5'd2, 5'd1, 32'd0, 11'd0), 1'b0, '0);
        add_row(op(KIND_SLT, 5'd0, 5'd2, 5'd1, 32'd0, 11'd0), 1'b0, '0);
        add_row(op(KIND_BEQ, 5'd0, 5'd0, 5'd0, 32'd0, 11'd1), 1'b0, '0);
        add_row(op(KIND_BNE, 5'd0, 5'd0, 5'd0, 32'd0, 11'd1), 1'b0, '0);
        add_row(op(KIND_BEQ, 5'd1, 5'd2, 5'd0, 32'd0, 11'd2), 1'b0, '0);
        add_row(op(KIND_J, 5'd0, 5'd0, 5'd0, 32'd0, 11'd1024), 1'b0, '0);
        add_row(op(KIND_J, 5'd0, 5'd0, 5'd0, 32'd0, 11'd1), 1'b0, '0);
        add_row(op(KIND_SW, 5'd3, 5'd0, 5'd0, 32'd0, 11'd0), 1'b0, '0);
        add_row(op(KIND_LW, 5'd8, 5'd0, 5'd0, 32'd0, 11'd0), 1'b0, '0);
        add_row(op(KIND_SW, 5'd1, 5'd0, 5'd0, 32'h000F_FFFC, 11'd0), 1'b0, '0);
        add_row(op(KIND_LW, 5'd9, 5'd0, 5'd0, 32'h000F_FFFC, 11'd0), 1'b0, '0);
        add_row(op(KIND_SW, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFC, 11'd0), 1'b0, '0);
        add_row(op(KIND_LW, 5'd10, 5'd0, 5'd0, 32'hFFFF_FFFC, 11'd0), 1'b0, '0);

        lens[0] = 11'd1024;
        lens[1] = 11'h7FF;
        lens[2] = 11'd16;
        lens[3] = $urandom_range(2, 1023);
        lens[4] = 11'd1;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[n]) send_instr(dir_rows[n].ins, dir_rows[n].typed, dir_rows[n].want);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            set_program_length(lens[p]);
            if (p == 2) begin
                // Fill the stack past full, then drain it past empty.
                repeat (STACK_DEPTH - stk_level + 3) send_instr(stack_instr(KIND_SW), 1'b0, '0);
                repeat (STACK_DEPTH + 3) send_instr(stack_instr(KIND_LW), 1'b0, '0);
            end
            repeat (ITEMS_PER_PHASE) send_instr(random_instr(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0)
            flag_mismatch("results never delivered", pending_results.size(), 0);

        $display("Ran %0d instructions under %0d program lengths; %0d results checked, %0d %s",
                 items_sent, NUM_PHASES + 1, results_seen, error_results,
                 "of them refused with an error code.");
        $display("Stack peaked at %0d entries; the receiver held off once for %0d cycles.",
                 stk_peak, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("tb_mips_subset_execute_step: clean");
        end else begin
            $display("tb_mips_subset_execute_step: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/mse_pkg.sv
sv/mse_ram.sv
sv/mips_subset_execute_step.sv
sv/mse_checker.sv
sim/tb_mips_subset_execute_step.sv
